>>> hdl/lwbc_pkg.sv
// Package for the LRU write-back block cache tag unit.
// Holds sizes, command and action codes, the controller state type and the cell view and cell write structs.
// No dependencies.
package lwbc_pkg;

    localparam int ENTRIES = 32;
    localparam int SLOT_W  = 6;
    localparam int BLK_W   = 32;
    localparam int STAMP_W = 64;
    localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

    localparam logic [1:0] CMD_READ  = 2'd0;
    localparam logic [1:0] CMD_WRITE = 2'd1;
    localparam logic [1:0] CMD_FLUSH = 2'd2;
    localparam logic [1:0] CMD_FAIL  = 2'd3;

    localparam logic [2:0] ACT_HIT       = 3'd0;
    localparam logic [2:0] ACT_FILL      = 3'd1;
    localparam logic [2:0] ACT_WRITEBACK = 3'd2;
    localparam logic [2:0] ACT_CLAIM     = 3'd3;
    localparam logic [2:0] ACT_DONE      = 3'd4;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DECIDE,
        ST_FLUSH,
        ST_DONE
    } t_state;

    // Per-cell view that the controller sees each cycle.
    typedef struct packed {
        logic               valid;
        logic               dirty;
        logic [BLK_W-1:0]   tag;
        logic [STAMP_W-1:0] stamp;
    } t_cell_view;

    // Write command from the controller to the cells.
    typedef struct packed {
        logic               wr;
        logic [IDX_W-1:0]   idx;
        logic               valid;
        logic               dirty;
        logic               set_tag;
        logic [BLK_W-1:0]   tag;
        logic               set_stamp;
        logic [STAMP_W-1:0] stamp;
    } t_cell_wr;

endpackage

>>> hdl/lwbc_cell.sv
// One slot cell of the tag unit: valid, dirty, tag and use stamp.
// Its view circulates to the neighbor each rotate cycle. Uses lwbc_pkg.
module lwbc_cell (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_rot,
    input  logic                 i_sel,
    input  lwbc_pkg::t_cell_wr   i_wr,
    input  lwbc_pkg::t_cell_view i_prev,
    output lwbc_pkg::t_cell_view o_view
);
    import lwbc_pkg::*;

    t_cell_view r_v, n_v;

    always_comb begin
        n_v = r_v;
        if (i_rot) begin
            n_v = i_prev;
        end else if (i_sel && i_wr.wr) begin
            n_v.valid = i_wr.valid;
            n_v.dirty = i_wr.dirty;
            if (i_wr.set_tag) n_v.tag = i_wr.tag;
            if (i_wr.set_stamp) n_v.stamp = i_wr.stamp;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v.valid <= 1'b0;
            r_v.dirty <= 1'b0;
            r_v.stamp <= '0;
            r_v.tag   <= n_v.tag;
        end else begin
            r_v <= n_v;
        end
    end

    assign o_view = r_v;
endmodule

>>> hdl/lru_writeback_block_cache_tags_unit.sv
// Top level of the LRU write-back disk block cache tag unit.
// Depends on lwbc_pkg and lwbc_cell.
//
// The slots sit in a ring of ENTRIES cells. For a read, write or flush the ring
// rotates once around, one slot per cycle. The head cell is compared against the
// request and checked for the first invalid slot and for the oldest stamp, or it
// is written back if dirty during a flush.
// A read or write rotates the ring once around and then decides, and its decide
// beat is shown at the edge that leaves ST_DECIDE. When a dirty victim
// has to be written back first, that beat comes then and the fill or claim beat
// one cycle later. busy drops at the edge that shows the last beat, so the next
// command can be accepted while that beat is shown.
// A flush rotates the ring once around, then in ST_DONE clears the dirty bit of
// each dirty slot that it found, one slot at a time, and then shows the done beat.
// A fill-failed command takes effect at its accepting edge and never raises busy.
// Results are shown for one cycle on o_valid and must be taken then, since the
// receiver cannot stall. A flush beat appears while the ring moves, one writeback
// per dirty slot.
module lru_writeback_block_cache_tags_unit (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic [1:0]                  i_cmd,
    input  logic [lwbc_pkg::BLK_W-1:0]  i_block_number,
    input  logic [lwbc_pkg::SLOT_W-1:0] i_failed_slot,
    output logic                        o_valid,
    output logic [2:0]                  o_action,
    output logic [lwbc_pkg::SLOT_W-1:0] o_slot,
    output logic [lwbc_pkg::BLK_W-1:0]  o_disk_block,
    output logic                        o_last
);
    import lwbc_pkg::*;

    t_state r_st, n_st;
    logic [1:0]         r_cmd;
    logic [BLK_W-1:0]   r_blk;
    logic [IDX_W:0]     r_cnt;      // cells visited in this pass
    logic [IDX_W-1:0]   r_pos;      // slot number at the ring head
    logic               r_hit, r_inv;
    logic [IDX_W-1:0]   r_hit_i, r_inv_i, r_old_i;
    logic [STAMP_W-1:0] r_old_s;
    logic [STAMP_W-1:0] r_use;
    logic               r_ov;
    logic [2:0]         r_act;
    logic [SLOT_W-1:0]  r_slot;
    logic [BLK_W-1:0]   r_db;
    logic               r_last;
    logic               r_fpend;
    logic [IDX_W-1:0]   fidx;

    logic               n_ov;
    logic [2:0]         n_act;
    logic [SLOT_W-1:0]  n_slot;
    logic [BLK_W-1:0]   n_db;
    logic               n_last;

    t_cell_view view [ENTRIES];
    t_cell_view head;
    t_cell_wr   wr;
    logic       rot;
    logic       wb_now;
    logic [IDX_W-1:0] vic;
    logic       vic_valid, vic_dirty;
    logic [BLK_W-1:0] vic_tag;
    logic [STAMP_W-1:0] use_nx;

    // Ring rotates so the cell at index 0 holds slot r_pos; after a full pass the
    // ring is back in its home order, so writes by slot index land in place.
    assign head = view[0];
    assign rot  = (r_st == ST_SCAN) || (r_st == ST_FLUSH);
    assign use_nx = r_use + 64'd1;
    assign wb_now = (r_st == ST_FLUSH) && head.valid && head.dirty;
    assign vic = r_hit ? r_hit_i : (r_inv ? r_inv_i : r_old_i);
    assign vic_valid = view[vic].valid;
    assign vic_dirty = view[vic].dirty;
    assign vic_tag   = view[vic].tag;

    genvar g;
    generate
        for (g = 0; g < ENTRIES; g++) begin : g_cell
            lwbc_cell u_cell (
                .i_clk  (i_clk),
                .i_rst_n(i_rst_n),
                .i_rot  (rot),
                .i_sel  (wr.idx == IDX_W'(g)),
                .i_wr   (wr),
                .i_prev (view[(g + 1) % ENTRIES]),
                .o_view (view[g])
            );
        end
    endgenerate

    // Cell write command; a write to the head while rotating would be lost, since the
    // cell takes the neighbor value, so flush dirty clearing is done at
    // the end through a pending mask instead: see r_clr below.
    logic [ENTRIES-1:0] r_clr;

    always_comb begin
        wr = '0;
        if (r_st == ST_IDLE && start && i_cmd == CMD_FAIL &&
            {1'b0, i_failed_slot} < (SLOT_W+1)'(ENTRIES)) begin
            wr.wr = 1'b1;
            wr.idx = i_failed_slot[IDX_W-1:0];
        end else if (r_st == ST_DECIDE) begin
            wr.wr = 1'b1;
            wr.idx = vic;
            wr.set_stamp = 1'b1;
            wr.stamp = use_nx;
            wr.valid = 1'b1;
            if (r_hit) begin
                wr.dirty = vic_dirty | (r_cmd == CMD_WRITE);
            end else begin
                wr.set_tag = 1'b1;
                wr.tag = r_blk;
                wr.dirty = (r_cmd == CMD_WRITE);
            end
        end else if (r_st == ST_DONE && r_fpend) begin
            wr.wr = 1'b1;
            wr.idx = fidx;
            wr.valid = view[fidx].valid;
            wr.dirty = 1'b0;
        end
    end

    always_comb begin
        n_st = r_st;
        unique case (r_st)
            ST_IDLE: if (start) begin
                if (i_cmd == CMD_FAIL) n_st = ST_IDLE;
                else if (i_cmd == CMD_FLUSH) n_st = ST_FLUSH;
                else n_st = ST_SCAN;
            end
            ST_SCAN:   if (r_cnt == (IDX_W+1)'(ENTRIES-1)) n_st = ST_DECIDE;
            ST_DECIDE: n_st = (r_hit || !(vic_valid && vic_dirty)) ? ST_IDLE : ST_DONE;
            ST_FLUSH:  if (r_cnt == (IDX_W+1)'(ENTRIES-1)) n_st = ST_DONE;
            ST_DONE:   n_st = r_fpend ? ST_DONE : ST_IDLE;
            default:   n_st = ST_IDLE;
        endcase
    end

    always_comb begin
        busy = (r_st != ST_IDLE);
    end

    // Next result beat. A flush shows a writeback whenever the head is dirty; a read
    // or write shows its beat when deciding, and a fill or claim that follows a
    // dirty victim's writeback in ST_DONE. The done beat of a flush waits until
    // all dirty bits are cleared.
    always_comb begin
        n_ov   = 1'b0;
        n_act  = r_act;
        n_slot = r_slot;
        n_db   = r_db;
        n_last = 1'b1;
        if (wb_now) begin
            n_ov   = 1'b1;
            n_act  = ACT_WRITEBACK;
            n_slot = SLOT_W'(r_pos);
            n_db   = head.tag;
            n_last = 1'b0;
        end else if (r_st == ST_DECIDE) begin
            n_ov   = 1'b1;
            n_slot = SLOT_W'(vic);
            if (r_hit) begin
                n_act = ACT_HIT;
                n_db  = r_blk;
            end else if (vic_valid && vic_dirty) begin
                n_act  = ACT_WRITEBACK;
                n_db   = vic_tag;
                n_last = 1'b0;
            end else begin
                n_act = (r_cmd == CMD_READ) ? ACT_FILL : ACT_CLAIM;
                n_db  = r_blk;
            end
        end else if (r_st == ST_DONE) begin
            if (r_cmd == CMD_FLUSH) begin
                if (!r_fpend) begin
                    n_ov   = 1'b1;
                    n_act  = ACT_DONE;
                    n_slot = '0;
                    n_db   = '0;
                end
            end else begin
                n_ov   = 1'b1;
                n_act  = (r_cmd == CMD_READ) ? ACT_FILL : ACT_CLAIM;
                n_slot = SLOT_W'(vic);
                n_db   = r_blk;
            end
        end
    end

    // Flush dirty clearing: each dirty slot seen is cleared one per cycle in ST_DONE.
    logic [IDX_W-1:0] clr_i;
    logic             clr_any;
    always_comb begin
        clr_i = '0;
        clr_any = 1'b0;
        for (int k = ENTRIES - 1; k >= 0; k--) begin
            if (r_clr[k]) begin
                clr_i = IDX_W'(k);
                clr_any = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= ST_IDLE;
            r_use <= '0;
            r_ov <= 1'b0;
            r_clr <= '0;
            r_fpend <= 1'b0;
        end else begin
            r_st <= n_st;
            r_ov <= n_ov;
            r_act <= n_act;
            r_slot <= n_slot;
            r_db <= n_db;
            r_last <= n_last;
            if (r_st == ST_IDLE && start) begin
                r_cmd <= i_cmd;
                r_blk <= i_block_number;
                r_cnt <= '0;
                r_pos <= '0;
                r_hit <= 1'b0;
                r_inv <= 1'b0;
                r_old_i <= '0;
                r_old_s <= view[0].stamp;
            end
            if (rot) begin
                r_cnt <= r_cnt + 1'b1;
                r_pos <= r_pos + 1'b1;
                if (r_st == ST_SCAN) begin
                    if (head.valid && head.tag == r_blk && !r_hit) begin
                        r_hit <= 1'b1;
                        r_hit_i <= r_pos;
                    end
                    if (!head.valid && !r_inv) begin
                        r_inv <= 1'b1;
                        r_inv_i <= r_pos;
                    end
                    if (head.stamp < r_old_s) begin
                        r_old_s <= head.stamp;
                        r_old_i <= r_pos;
                    end
                end
                if (wb_now) begin
                    r_clr[r_pos] <= 1'b1;
                end
                if (r_st == ST_FLUSH && r_cnt == (IDX_W+1)'(ENTRIES-1)) begin
                    r_fpend <= clr_any || wb_now;
                end
            end
            if (r_st == ST_DECIDE) begin
                r_use <= use_nx;
            end
            if (r_st == ST_DONE && r_cmd == CMD_FLUSH && r_fpend) begin
                r_clr[fidx] <= 1'b0;
                r_fpend <= |(r_clr & ~(ENTRIES'(1) << fidx));
            end
        end
    end

    always_comb fidx = clr_i;

    assign o_valid      = r_ov;
    assign o_action     = r_act;
    assign o_slot       = r_slot;
    assign o_disk_block = r_db;
    assign o_last       = r_last;
endmodule

>>> hdl/lwbc_checker.sv
// Port-level checker for the tag unit, bound to the top level.
// Depends on lwbc_pkg.
module lwbc_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       start,
    input logic       busy,
    input logic [1:0] i_cmd,
    input logic       o_valid,
    input logic [2:0] o_action,
    input logic       o_last
);
    import lwbc_pkg::*;

    a_act: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_action <= ACT_DONE)) else $error("bad action");
    a_done_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_action == ACT_DONE) |-> o_last) else $error("done not last");
    a_wb_notlast: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_action == ACT_WRITEBACK) |-> !o_last) else $error("wb last");
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_cmd != CMD_FAIL) |=> busy) else $error("not busy");
endmodule

bind lru_writeback_block_cache_tags_unit lwbc_checker u_chk (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy), .i_cmd(i_cmd),
    .o_valid(o_valid), .o_action(o_action), .o_last(o_last)
);
